### hw/rtl/usbkd_pkg.sv
// Shared types and constants of the ultrasonic band key decoder.
// Holds mode codes, register indexes, clamp limits and the character tables.
// No dependencies.
package usbkd_pkg;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_BLUE  = 2'd1,
      MODE_RED   = 2'd2,
      MODE_WHITE = 2'd3
   } mode_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_FACTOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_LIMIT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_CENTER    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_STEP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_TOLERANCE  = 3'd4;

   localparam logic [15:0] DISTANCE_FACTOR_RESET = 16'd1124;
   localparam logic [15:0] GATE_LIMIT_RESET      = 16'd4352;
   localparam logic [15:0] FIRST_CENTER_RESET    = 16'd1024;
   localparam logic [15:0] CENTER_STEP_RESET     = 16'd768;
   localparam logic [19:0] BAND_TOLERANCE_RESET  = 20'd2048;

   localparam logic [14:0] ECHO_CLAMP = 15'd20000;
   localparam int          SUM_W      = 20;
   localparam int          BAND_IDX_W = 3;

   localparam logic [6:0] LEFT_TAB [0:3][0:7] = '{
      '{7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h2A, 7'h2A, 7'h2A},
      '{7'h46, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h2A, 7'h2A, 7'h2A},
      '{7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h2A, 7'h2A, 7'h2A},
      '{7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h2A, 7'h2A, 7'h2A}
   };

   localparam logic [6:0] RIGHT_TAB [0:3][0:7] = '{
      '{7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h2A, 7'h2A, 7'h2A},
      '{7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h2A, 7'h2A, 7'h2A},
      '{7'h5A, 7'h20, 7'h2E, 7'h2C, 7'h3B, 7'h2A, 7'h2A, 7'h2A},
      '{7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h2A, 7'h2A, 7'h2A}
   };

endpackage

### hw/rtl/ultrasonic_band_key_decoder_unit.sv
// Top level of the ultrasonic band key decoder: distance, gating, sums and band match.
// Depends on usbkd_pkg.
//
// The decoder takes one transfer per cycle on the req_ channel while req_stall is low
// and, after the last echo sample of a frame, returns one transfer on the rsp_ channel
// once that sample has passed the input register, the distance stage with the 15x16
// multiplier, the sum stage and the band match into the result register. A button
// transfer restarts the frame and gives no result. When rsp_stall holds a waiting
// result, the whole pipeline holds and req_stall rises. Band centres are rebuilt into
// the centre registers from the configuration registers that a csr_ write updates.
module ultrasonic_band_key_decoder_unit #(
   parameter int SAMPLES_PER_SIDE = 20,
   parameter int BAND_COUNT       = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic                              req_blue_level,
   input  logic                              req_red_level,
   input  logic                              req_white_level,
   input  logic [14:0]                       req_echo_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_mode,
   output logic                              rsp_left_valid,
   output logic [6:0]                        rsp_left_char,
   output logic                              rsp_right_valid,
   output logic [6:0]                        rsp_right_char,
   output logic [19:0]                       rsp_left_total,
   output logic [19:0]                       rsp_right_total,
   input  logic                              csr_write,
   input  logic [usbkd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [usbkd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import usbkd_pkg::*;

   localparam int FRAME_LEN = 2 * SAMPLES_PER_SIDE;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam int HALF      = SAMPLES_PER_SIDE / 2;
   localparam int BASE_W    = 16 + $clog2(BAND_COUNT);
   localparam int CW        = BASE_W + $clog2(HALF + 1);
   localparam int MW        = (CW > SUM_W) ? CW : SUM_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
   localparam logic [IDX_W-1:0] SIDE_IDX = IDX_W'(SAMPLES_PER_SIDE);

   // configuration
   logic [15:0]       factor_ff, gate_ff, first_ff, step_ff;
   logic [SUM_W-1:0]  tol_ff;
   logic [CW-1:0]     center_ff [BAND_COUNT];
   logic [CW-1:0]     center_in [BAND_COUNT];

   // pipeline
   logic              advance;
   logic              s1_valid_ff, s1_cmd_ff;
   logic [2:0]        s1_levels_ff;
   logic [14:0]       s1_echo_ff;
   logic              s2_valid_ff, s2_cmd_ff, s2_pass_ff;
   logic [2:0]        s2_levels_ff;
   logic [15:0]       s2_dist_ff;
   logic [14:0]       echo_clamped;
   logic [30:0]       product;
   logic [22:0]       distance;

   // frame state
   logic [2:0]        last_ff, last_in;
   mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  right_ff, right_in, left_ff, left_in;
   logic [SUM_W:0]    acc_sum;
   logic [2:0]        fell;
   logic              is_last;

   logic              s3_done_ff;
   mode_type          s3_mode_ff;
   logic [SUM_W-1:0]  s3_left_ff, s3_right_ff;

   // band match and result
   logic                  left_hit, right_hit;
   logic [BAND_IDX_W-1:0] left_band, right_band;
   logic                  rsp_valid_ff, rsp_left_valid_ff, rsp_right_valid_ff;
   mode_type              rsp_mode_ff;
   logic [6:0]            rsp_left_char_ff, rsp_right_char_ff;
   logic [SUM_W-1:0]      rsp_left_total_ff, rsp_right_total_ff;

   function automatic logic near_band(input logic [SUM_W-1:0] sum,
                                      input logic [CW-1:0]    center,
                                      input logic [SUM_W-1:0] tol);
      logic [MW-1:0] s;
      logic [MW-1:0] c;
      logic [MW-1:0] d;
      s = MW'(sum);
      c = MW'(center);
      d = (s >= c) ? (s - c) : (c - s);
      return d < MW'(tol);
   endfunction

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= DISTANCE_FACTOR_RESET;
         gate_ff   <= GATE_LIMIT_RESET;
         first_ff  <= FIRST_CENTER_RESET;
         step_ff   <= CENTER_STEP_RESET;
         tol_ff    <= BAND_TOLERANCE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DISTANCE_FACTOR: factor_ff <= csr_data[15:0];
            CSR_GATE_LIMIT:      gate_ff   <= csr_data[15:0];
            CSR_FIRST_CENTER:    first_ff  <= csr_data[15:0];
            CSR_CENTER_STEP:     step_ff   <= csr_data[15:0];
            CSR_BAND_TOLERANCE:  tol_ff    <= csr_data[SUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < BAND_COUNT; k++) begin
         center_in[k] = CW'(BASE_W'(first_ff) + BASE_W'(k) * BASE_W'(step_ff)) * CW'(HALF);
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
   end

   // distance stage
   always_comb begin
      echo_clamped = (s1_echo_ff > ECHO_CLAMP) ? ECHO_CLAMP : s1_echo_ff;
      product      = 31'(echo_clamped) * 31'(factor_ff);
      distance     = product[30:8];
   end

   // sum stage
   always_comb begin
      last_in  = last_ff;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      right_in = right_ff;
      left_in  = left_ff;
      fell     = last_ff & ~s2_levels_ff;
      is_last  = 1'b0;
      acc_sum  = '0;
      if (s2_valid_ff && !s2_cmd_ff) begin
         if (fell[0]) begin
            mode_in = (mode_ff == MODE_BLUE) ? MODE_NONE : MODE_BLUE;
         end else if (fell[2]) begin
            mode_in = (mode_ff == MODE_WHITE) ? MODE_NONE : MODE_WHITE;
         end else if (fell[1]) begin
            mode_in = (mode_ff == MODE_RED) ? MODE_NONE : MODE_RED;
         end
         last_in  = s2_levels_ff;
         idx_in   = '0;
         right_in = '0;
         left_in  = '0;
      end else if (s2_valid_ff) begin
         if (idx_ff < SIDE_IDX) begin
            acc_sum = {1'b0, right_ff} + (SUM_W + 1)'(s2_dist_ff);
         end else begin
            acc_sum = {1'b0, left_ff} + (SUM_W + 1)'(s2_dist_ff);
         end
         if (idx_ff[0] && s2_pass_ff) begin
            if (idx_ff < SIDE_IDX) begin
               right_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
            end else begin
               left_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
            end
         end
         is_last = (idx_ff == LAST_IDX);
         idx_in  = is_last ? '0 : IDX_W'(idx_ff + 1'b1);
      end
   end

   // band match
   always_comb begin
      left_hit   = 1'b0;
      right_hit  = 1'b0;
      left_band  = '0;
      right_band = '0;
      for (int k = BAND_COUNT - 1; k >= 0; k--) begin
         if (near_band(s3_left_ff, center_ff[k], tol_ff)) begin
            left_hit  = 1'b1;
            left_band = BAND_IDX_W'(k);
         end
         if (near_band(s3_right_ff, center_ff[k], tol_ff)) begin
            right_hit  = 1'b1;
            right_band = BAND_IDX_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         mode_ff      <= MODE_NONE;
         idx_ff       <= '0;
         right_ff     <= '0;
         left_ff      <= '0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_done_ff   <= is_last;
         rsp_valid_ff <= s3_done_ff;
         last_ff      <= last_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         right_ff     <= is_last ? '0 : right_in;
         left_ff      <= is_last ? '0 : left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff          <= req_command;
         s1_levels_ff       <= {req_white_level, req_red_level, req_blue_level};
         s1_echo_ff         <= req_echo_time;
         s2_cmd_ff          <= s1_cmd_ff;
         s2_levels_ff       <= s1_levels_ff;
         s2_dist_ff         <= distance[15:0];
         s2_pass_ff         <= (distance <= {7'd0, gate_ff});
         s3_mode_ff         <= mode_ff;
         s3_left_ff         <= left_in;
         s3_right_ff        <= right_in;
         rsp_mode_ff        <= s3_mode_ff;
         rsp_left_valid_ff  <= left_hit;
         rsp_right_valid_ff <= right_hit;
         rsp_left_char_ff   <= left_hit ? LEFT_TAB[s3_mode_ff][left_band] : 7'd0;
         rsp_right_char_ff  <= right_hit ? RIGHT_TAB[s3_mode_ff][right_band] : 7'd0;
         rsp_left_total_ff  <= s3_left_ff;
         rsp_right_total_ff <= s3_right_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode        = rsp_mode_ff;
   assign rsp_left_valid  = rsp_left_valid_ff;
   assign rsp_left_char   = rsp_left_char_ff;
   assign rsp_right_valid = rsp_right_valid_ff;
   assign rsp_right_char  = rsp_right_char_ff;
   assign rsp_left_total  = rsp_left_total_ff;
   assign rsp_right_total = rsp_right_total_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("sample index past frame end");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      s3_done_ff |-> (idx_ff == '0 && left_ff == '0 && right_ff == '0))
      else $error("frame end did not restart the frame");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("transfer taken while result is held");

   a_left_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_left_valid_ff) |-> (rsp_left_char_ff == 7'd0))
      else $error("left char without band match");

   a_right_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_right_valid_ff) |-> (rsp_right_char_ff == 7'd0))
      else $error("right char without band match");

endmodule

### tb/tb_ultrasonic_band_key_decoder_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for ultrasonic_band_key_decoder_unit: a directed frame
// script, then random frames under several register settings, checked by a local
// decoder or by typed results. Depends on usbkd_pkg and the unit under test.
module tb_ultrasonic_band_key_decoder_unit;
   import usbkd_pkg::*;

   localparam int SIDE        = 20;
   localparam int BANDS       = 5;
   localparam int HALF        = SIDE / 2;
   localparam int LATENCY     = 3;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 140;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic CMD_BUTTON = 1'b0;
   localparam logic CMD_ECHO   = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [14:0] ECHO_LIMIT = 15'd20000;
   localparam logic [19:0] SUM_LIMIT  = 20'hFFFFF;

   localparam logic [39:0] LEFT_KEYS [4]  = '{"ABCDE", "FGHIJ", "KLMNO", "01234"};
   localparam logic [39:0] RIGHT_KEYS [4] = '{"PQRST", "UVWXY", "Z .,;", "56789"};

   typedef struct packed {
      logic        command;
      logic        blue;
      logic        red;
      logic        white;
      logic [14:0] echo;
   } key_item_t;

   typedef struct packed {
      mode_type    mode;
      logic        left_valid;
      logic [6:0]  left_char;
      logic        right_valid;
      logic [6:0]  right_char;
      logic [19:0] left_total;
      logic [19:0] right_total;
   } key_result_t;

   typedef struct packed {
      logic [15:0] factor;
      logic [15:0] gate;
      logic [15:0] first;
      logic [15:0] step;
      logic [19:0] tol;
   } reg_set_t;

   typedef struct packed {
      logic        press;
      logic [2:0]  levels;
      logic [5:0]  echoes;
      logic [14:0] right_echo;
      logic [14:0] left_echo;
      logic [14:0] even_echo;
      logic        typed;
      key_result_t want;
   } frame_row_t;

   localparam reg_set_t    RESET_REGS = '{16'd1124, 16'd4352, 16'd1024, 16'd768, 20'd2048};
   localparam key_result_t NO_KEY     = '0;
   localparam key_result_t FIRST_BAND =
      '{MODE_NONE, 1'b1, 7'h41, 1'b1, 7'h50, 20'd10230, 20'd10230};

   // levels are {white, red, blue}
   localparam frame_row_t SCRIPT [19] = '{
      '{1'b1, 3'b000, 6'd40, 15'd233,   15'd233,   15'd233,   1'b1, FIRST_BAND},
      '{1'b0, 3'b000, 6'd40, 15'd0,     15'd0,     15'd0,     1'b1, NO_KEY},
      '{1'b0, 3'b000, 6'd40, 15'd32767, 15'd32767, 15'd32767, 1'b1, NO_KEY},
      '{1'b0, 3'b000, 6'd40, 15'd991,   15'd992,   15'd20000, 1'b0, NO_KEY},
      '{1'b0, 3'b000, 6'd40, 15'd408,   15'd933,   15'd20001, 1'b0, NO_KEY},
      '{1'b1, 3'b111, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd40, 15'd233,   15'd1000,  15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b100, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd40, 15'd583,   15'd408,   15'd32767, 1'b0, NO_KEY},
      '{1'b1, 3'b010, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd40, 15'd933,   15'd583,   15'd1,     1'b0, NO_KEY},
      '{1'b1, 3'b010, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd40, 15'd408,   15'd233,   15'd16384, 1'b0, NO_KEY},
      '{1'b1, 3'b111, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b110, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd17, 15'd233,   15'd233,   15'd233,   1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd40, 15'd233,   15'd583,   15'd5,     1'b0, NO_KEY},
      '{1'b1, 3'b001, 6'd0,  15'd0,     15'd0,     15'd0,     1'b0, NO_KEY},
      '{1'b1, 3'b000, 6'd40, 15'd583,   15'd933,   15'd10000, 1'b0, NO_KEY}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_command;
   logic                   req_blue_level;
   logic                   req_red_level;
   logic                   req_white_level;
   logic [14:0]            req_echo_time;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_mode;
   logic                   rsp_left_valid;
   logic [6:0]             rsp_left_char;
   logic                   rsp_right_valid;
   logic [6:0]             rsp_right_char;
   logic [19:0]            rsp_left_total;
   logic [19:0]            rsp_right_total;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   reg_set_t    key_cfg     = RESET_REGS;
   logic [2:0]  held_levels = 3'b000;
   mode_type    key_mode    = MODE_NONE;
   int          frame_pos   = 0;
   logic [19:0] right_acc   = '0;
   logic [19:0] left_acc    = '0;

   key_result_t pending_keys [$];
   key_result_t due;
   bit          calm = 1'b0;
   int          failures = 0;
   int          cycle_count = 0;

   ultrasonic_band_key_decoder_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_blue_level(req_blue_level), .req_red_level(req_red_level),
      .req_white_level(req_white_level), .req_echo_time(req_echo_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_mode(rsp_mode),
      .rsp_left_valid(rsp_left_valid), .rsp_left_char(rsp_left_char),
      .rsp_right_valid(rsp_right_valid), .rsp_right_char(rsp_right_char),
      .rsp_left_total(rsp_left_total), .rsp_right_total(rsp_right_total),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic mode_type flip_mode(input mode_type target);
      return (key_mode == target) ? MODE_NONE : target;
   endfunction

   function automatic logic [19:0] sat_sum(input logic [19:0] acc, input logic [31:0] addend);
      logic [32:0] total;
      total = 33'(acc) + 33'(addend);
      return (total > 33'(SUM_LIMIT)) ? SUM_LIMIT : total[19:0];
   endfunction

   function automatic int band_of(input logic [19:0] sum);
      longint centre, gap;
      for (int k = 0; k < BANDS; k++) begin
         centre = (longint'(key_cfg.first) + longint'(k) * longint'(key_cfg.step)) * HALF;
         gap = (longint'(sum) >= centre) ? longint'(sum) - centre : centre - longint'(sum);
         if (gap < longint'(key_cfg.tol)) return k + 1;
      end
      return 0;
   endfunction

   // Advance the local decoder by one transfer; return 1 when a key comes out.
   function automatic bit decode_item(input key_item_t it, output key_result_t key);
      logic [2:0]  now, fell;
      logic [14:0] echo;
      logic [31:0] distance;
      int          lb, rb;
      key = '0;
      if (it.command == CMD_BUTTON) begin
         now  = {it.white, it.red, it.blue};
         fell = held_levels & ~now;
         if (fell[0]) key_mode = flip_mode(MODE_BLUE);
         else if (fell[2]) key_mode = flip_mode(MODE_WHITE);
         else if (fell[1]) key_mode = flip_mode(MODE_RED);
         held_levels = now;
         frame_pos = 0;
         right_acc = '0;
         left_acc = '0;
         return 1'b0;
      end
      echo = (it.echo > ECHO_LIMIT) ? ECHO_LIMIT : it.echo;
      distance = (32'(echo) * 32'(key_cfg.factor)) >> 8;
      if (frame_pos % 2 == 1 && distance <= 32'(key_cfg.gate)) begin
         if (frame_pos < SIDE) right_acc = sat_sum(right_acc, distance);
         else left_acc = sat_sum(left_acc, distance);
      end
      frame_pos++;
      if (frame_pos < 2 * SIDE) return 1'b0;
      lb = band_of(left_acc);
      rb = band_of(right_acc);
      key.mode = key_mode;
      key.left_valid = (lb != 0);
      key.left_char = (lb != 0) ? LEFT_KEYS[key_mode][8 * (BANDS - lb) +: 7] : 7'd0;
      key.right_valid = (rb != 0);
      key.right_char = (rb != 0) ? RIGHT_KEYS[key_mode][8 * (BANDS - rb) +: 7] : 7'd0;
      key.left_total = left_acc;
      key.right_total = right_acc;
      frame_pos = 0;
      right_acc = '0;
      left_acc = '0;
      return 1'b1;
   endfunction

   // Echo time near a band centre; past the last band or at factor zero, anything goes.
   function automatic logic [14:0] aim_echo(input int band);
      longint target, echo;
      if (key_cfg.factor == 0 || band >= BANDS) return 15'($urandom_range(0, 32767));
      target = longint'(key_cfg.first) + longint'(band) * longint'(key_cfg.step);
      echo = (target * 256 + longint'(key_cfg.factor) / 2) / longint'(key_cfg.factor)
             + longint'($urandom_range(0, 2)) - 1;
      if (echo < 0) echo = 0;
      if (echo > 32767) echo = 32767;
      return 15'(echo);
   endfunction

   function automatic void check_field(input string name, input logic [19:0] want, got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_keys.size() == 0) begin
            $display("%0t: key transfer with none expected, mode %0d totals %0d/%0d",
                     $time, rsp_mode, rsp_left_total, rsp_right_total);
            failures++;
         end else begin
            due = pending_keys.pop_front();
            check_field("mode", due.mode, rsp_mode);
            check_field("left_valid", due.left_valid, rsp_left_valid);
            check_field("left_char", due.left_char, rsp_left_char);
            check_field("right_valid", due.right_valid, rsp_right_valid);
            check_field("right_char", due.right_char, rsp_right_char);
            check_field("left_total", due.left_total, rsp_left_total);
            check_field("right_total", due.right_total, rsp_right_total);
         end
      end
   end

   task automatic send_item(input key_item_t it, input bit typed, input key_result_t want);
      key_result_t key;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_blue_level <= it.blue;
      req_red_level <= it.red;
      req_white_level <= it.white;
      req_echo_time <= it.echo;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      if (decode_item(it, key)) pending_keys.push_back(typed ? want : key);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [19:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic program_regs(input reg_set_t regs);
      write_reg(CSR_DISTANCE_FACTOR, {4'($urandom), regs.factor});
      write_reg(CSR_GATE_LIMIT, {4'($urandom), regs.gate});
      write_reg(CSR_FIRST_CENTER, {4'($urandom), regs.first});
      write_reg(CSR_CENTER_STEP, {4'($urandom), regs.step});
      write_reg(CSR_BAND_TOLERANCE, regs.tol);
      write_reg(CSR_FIRST_UNUSED + 3'($urandom_range(0, 2)), 20'($urandom));
      csr_write <= 1'b0;
      key_cfg = regs;
      repeat (2) @(posedge clock);
   endtask

   task automatic random_burst(inout int sent);
      key_item_t it;
      int        right_band, left_band, span;
      if ($urandom_range(0, 99) < 15) begin
         span = $urandom_range(1, 45);
         repeat (span) begin
            it.command = 1'($urandom);
            {it.white, it.red, it.blue} = 3'($urandom);
            it.echo = 15'($urandom);
            send_item(it, 1'b0, NO_KEY);
         end
         sent += span;
         return;
      end
      if (frame_pos != 0 || $urandom_range(0, 1)) begin
         it.command = CMD_BUTTON;
         {it.white, it.red, it.blue} = 3'($urandom);
         it.echo = 15'($urandom);
         send_item(it, 1'b0, NO_KEY);
         sent++;
      end
      right_band = $urandom_range(0, BANDS);
      left_band = $urandom_range(0, BANDS);
      for (int i = 0; i < 2 * SIDE; i++) begin
         it.command = CMD_ECHO;
         {it.white, it.red, it.blue} = 3'($urandom);
         if (i % 2 == 0 || $urandom_range(0, 9) == 0) it.echo = 15'($urandom);
         else it.echo = aim_echo(i < SIDE ? right_band : left_band);
         send_item(it, 1'b0, NO_KEY);
      end
      sent += 2 * SIDE;
   endtask

   initial begin : stimulus
      key_item_t it;
      reg_set_t  regs;
      int        sent;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_BUTTON;
      req_blue_level <= 1'b0;
      req_red_level <= 1'b0;
      req_white_level <= 1'b0;
      req_echo_time <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_DISTANCE_FACTOR;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[r]) begin
         if (SCRIPT[r].press) begin
            it.command = CMD_BUTTON;
            {it.white, it.red, it.blue} = SCRIPT[r].levels;
            it.echo = 15'($urandom);
            send_item(it, 1'b0, NO_KEY);
         end
         for (int i = 0; i < SCRIPT[r].echoes; i++) begin
            it.command = CMD_ECHO;
            {it.white, it.red, it.blue} = 3'($urandom);
            if (i % 2 == 0) it.echo = SCRIPT[r].even_echo;
            else if (i < SIDE) it.echo = SCRIPT[r].right_echo;
            else it.echo = SCRIPT[r].left_echo;
            send_item(it, SCRIPT[r].typed, SCRIPT[r].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: regs = RESET_REGS;
            1: regs = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 20'hFFFFF};
            2: regs = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 20'h00000};
            3: regs = '{16'd1, 16'hFFFF, 16'd100, 16'd50, 20'd600};
            default: regs = '{16'($urandom_range(256, 4096)), 16'($urandom_range(1000, 65535)),
                              16'($urandom_range(0, 8000)), 16'($urandom_range(0, 4000)),
                              20'($urandom_range(0, 20000))};
         endcase
         program_regs(regs);
         // hold both sides busy through the whole extreme phase
         calm = (phase == 1);
         sent = 0;
         while (sent < PHASE_ITEMS) random_burst(sent);
      end
      calm = 1'b0;
      drain();

      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
